@@ rtl/core/sacp_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sacp_pkg: shared definitions for the set-associative cache
// Cache geometry, address field widths, tag row layout and lookup result.
// ---------------------------------------------------------------------------
package sacp_pkg;

	// geometry
	localparam int SETS        = 64;
	localparam int WAYS        = 4;
	localparam int BLOCK_BYTES = 64;
	localparam int ADDR_BITS   = 48;

	// floor(log2) of the geometry
	localparam int OFF_BITS = $clog2(BLOCK_BYTES + 1) - 1;
	localparam int SET_BITS = $clog2(SETS + 1) - 1;
	localparam int SET_CNT  = 2 ** SET_BITS;
	localparam int TAG_W    = ADDR_BITS - OFF_BITS - SET_BITS;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [SET_BITS-1:0]  set_t;
	typedef logic [TAG_W-1:0]     tag_t;
	typedef logic [WAY_W-1:0]     way_t;
	typedef logic [WAYS-1:0]      way_mask_t;

	// one row of the tag memory: FIFO pointer plus all tags of a set
	typedef struct packed {
		way_t                 oldest;
		logic [WAYS-1:0][TAG_W-1:0] tags;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	// result of one tag lookup with fill
	typedef struct packed {
		logic      hit;
		row_t      row;
		way_mask_t valid;
	} lookup_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_PF   = 3'b100
	} state_t;

endpackage
`default_nettype wire

@@ rtl/core/sacp_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sacp_ram: generic simple dual-port RAM
// One write port and one read port; read data registered, held when idle.
// ---------------------------------------------------------------------------
module sacp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/sacp_lookup.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sacp_lookup: tag compare and FIFO fill for one set
// Compares a tag against the valid ways, picks the fill way on a miss
// (first invalid, else oldest) and builds the updated row and valid bits.
// ---------------------------------------------------------------------------
module sacp_lookup (
	input  wire sacp_pkg::row_t      row_in,
	input  wire sacp_pkg::way_mask_t valid_in,
	input  wire sacp_pkg::tag_t      tag,
	output sacp_pkg::lookup_t        res
);

	sacp_pkg::way_mask_t match;
	sacp_pkg::way_t      fill_way;
	sacp_pkg::way_t      old_way;
	logic                found;
	logic                full;

	// per-way compare
	always_comb begin
		for (int w = 0; w < sacp_pkg::WAYS; w++) begin
			match[w] = valid_in[w] && (row_in.tags[w] == tag);
		end
	end

	// fill way selection and row update
	always_comb begin
		found    = 1'b0;
		fill_way = '0;
		for (int w = 0; w < sacp_pkg::WAYS; w++) begin
			if (!found && !valid_in[w]) begin
				found    = 1'b1;
				fill_way = sacp_pkg::WAY_W'(w);
			end
		end
		full = &valid_in;
		// the pointer only moves once the set is full; before that it is zero
		old_way = row_in.oldest;
		if (!full || ({1'b0, old_way} >= (sacp_pkg::WAY_W + 1)'(sacp_pkg::WAYS))) begin
			old_way = '0;
		end
		if (!found) begin
			fill_way = old_way;
		end

		res.hit             = |match;
		res.row             = row_in;
		res.row.tags[fill_way] = tag;
		res.valid           = valid_in;
		res.valid[fill_way] = 1'b1;
		if (!full) begin
			res.row.oldest = '0;
		end else if (old_way == sacp_pkg::WAY_W'(sacp_pkg::WAYS - 1)) begin
			res.row.oldest = '0;
		end else begin
			res.row.oldest = old_way + 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/set_assoc_cache_with_next_line_prefetch.sv @@
`default_nettype none
// Result: registered in ST_LOOK on a hit or plain miss; on a miss with next-line
// prefetch, registered in ST_PF after a second tag memory lookup.
// Flow: one access in flight, the input stalls outside ST_IDLE, and the single tag
// memory read port serves both lookups; a stalled result holds the next lookup.
// Reset: valid bits and prefetch_enable clear at once, FIFO pointers count as
// zero until a set fills; no sweep.
// ---------------------------------------------------------------------------
// set_assoc_cache_with_next_line_prefetch: cache hit/miss tracker
// Set-associative tag store with FIFO replacement, write-through reporting
// and optional next-line prefetch on demand misses.
// ---------------------------------------------------------------------------
module set_assoc_cache_with_next_line_prefetch (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic                           cfg_data,
	// access input
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           operation,
	input  wire logic [sacp_pkg::ADDR_BITS-1:0] address,
	// result output
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                hit,
	output logic                                demand_fill_read,
	output logic                                prefetch_fill_read,
	output logic                                memory_write
);

	sacp_pkg::state_t state_q;
	logic             pf_en_q;

	sacp_pkg::addr_t  addr_s1;
	logic             op_s1;
	sacp_pkg::addr_t  pf_addr_q;
	logic             fwd_q;
	sacp_pkg::row_t   fwd_row_q;

	sacp_pkg::way_mask_t [sacp_pkg::SET_CNT-1:0] valid_q;

	logic out_valid_q, hit_q, dfr_q, pfr_q, mw_q;

	logic                in_acc, out_free, need_pf, do_out, do_fill;
	sacp_pkg::addr_t     next_addr, lk_addr;
	sacp_pkg::set_t      lk_set, next_set;
	sacp_pkg::row_t      rd_row, lk_row;
	sacp_pkg::lookup_t   lk_res;
	logic                rd_en;
	sacp_pkg::set_t      rd_addr;
	logic [sacp_pkg::ROW_W-1:0] rd_data;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != sacp_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pf_en_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			pf_en_q <= cfg_data;
		end
	end

	// lookup operand select: demand block or prefetch block
	assign lk_addr   = (state_q == sacp_pkg::ST_PF) ? pf_addr_q : addr_s1;
	assign lk_set    = lk_addr[sacp_pkg::OFF_BITS +: sacp_pkg::SET_BITS];
	assign rd_row    = sacp_pkg::row_t'(rd_data);
	assign lk_row    = (state_q == sacp_pkg::ST_PF && fwd_q) ? fwd_row_q : rd_row;
	assign next_addr = addr_s1 + sacp_pkg::ADDR_BITS'(sacp_pkg::BLOCK_BYTES);
	assign next_set  = next_addr[sacp_pkg::OFF_BITS +: sacp_pkg::SET_BITS];

	sacp_lookup u_lookup (
		.row_in   (lk_row),
		.valid_in (valid_q[lk_set]),
		.tag      (lk_addr[sacp_pkg::ADDR_BITS-1 -: sacp_pkg::TAG_W]),
		.res      (lk_res)
	);

	// control decisions
	always_comb begin
		need_pf = (state_q == sacp_pkg::ST_LOOK) && !lk_res.hit && pf_en_q;
		do_out  = ((state_q == sacp_pkg::ST_LOOK) || (state_q == sacp_pkg::ST_PF)) &&
			out_free && !need_pf;
		do_fill = !lk_res.hit && (need_pf || do_out);
		rd_en   = in_acc || need_pf;
		rd_addr = need_pf ? next_set :
			address[sacp_pkg::OFF_BITS +: sacp_pkg::SET_BITS];
	end

	sacp_ram #(
		.WIDTH (sacp_pkg::ROW_W),
		.DEPTH (sacp_pkg::SET_CNT)
	) u_tag_ram (
		.clk     (clk),
		.wr_en   (do_fill),
		.wr_addr (lk_set),
		.wr_data (lk_res.row),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sacp_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				sacp_pkg::ST_IDLE: begin
					if (in_acc) state_q <= sacp_pkg::ST_LOOK;
				end
				sacp_pkg::ST_LOOK: begin
					if (need_pf) state_q <= sacp_pkg::ST_PF;
					else if (do_out) state_q <= sacp_pkg::ST_IDLE;
				end
				sacp_pkg::ST_PF: begin
					if (do_out) state_q <= sacp_pkg::ST_IDLE;
				end
				default: state_q <= sacp_pkg::ST_IDLE;
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (do_fill) begin
			valid_q[lk_set] <= lk_res.valid;
		end
	end

	// access payload and prefetch forwarding
	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_s1 <= address;
			op_s1   <= operation;
		end
		if (need_pf) begin
			pf_addr_q <= next_addr;
			// row write and next-set read collide: keep the written row
			fwd_q     <= (next_set == lk_set);
			fwd_row_q <= lk_res.row;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_out) begin
			if (state_q == sacp_pkg::ST_PF) begin
				hit_q <= 1'b0;
				dfr_q <= 1'b1;
				pfr_q <= !lk_res.hit;
			end else begin
				hit_q <= lk_res.hit;
				dfr_q <= !lk_res.hit;
				pfr_q <= 1'b0;
			end
			mw_q <= op_s1;
		end
	end

	assign out_valid          = out_valid_q;
	assign hit                = hit_q;
	assign demand_fill_read   = dfr_q;
	assign prefetch_fill_read = pfr_q;
	assign memory_write       = mw_q;

endmodule
`default_nettype wire

@@ rtl/core/sacp_checker.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sacp_checker: port-level assertions for the cache
// Checks result consistency and the one-access-in-flight input behavior.
// ---------------------------------------------------------------------------
module sacp_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_stall,
	input wire logic                           operation,
	input wire logic [sacp_pkg::ADDR_BITS-1:0] address,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic                           hit,
	input wire logic                           demand_fill_read,
	input wire logic                           prefetch_fill_read,
	input wire logic                           memory_write
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid &&
		$stable({hit, demand_fill_read, prefetch_fill_read, memory_write}))
		else $error("stalled result changed");

	// every miss reports a fill read, every hit none
	a_miss_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (demand_fill_read == !hit))
		else $error("demand fill read does not match hit");

	// prefetch only follows a demand miss
	a_pf_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && prefetch_fill_read |-> !hit)
		else $error("prefetch reported on a hit");

	// only one access in flight: input stalls right after a transaction
	a_one_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second access taken while one is in flight");

	// a stalled access holds its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable({operation, address}))
		else $error("stalled access changed");

endmodule

bind set_assoc_cache_with_next_line_prefetch sacp_checker u_sacp_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_valid),
	.in_stall           (in_stall),
	.operation          (operation),
	.address            (address),
	.out_valid          (out_valid),
	.out_stall          (out_stall),
	.hit                (hit),
	.demand_fill_read   (demand_fill_read),
	.prefetch_fill_read (prefetch_fill_read),
	.memory_write       (memory_write)
);
`default_nettype wire
